// ----- design/smx_pkg.sv -----
// shared constants, opcode and status codes and control types of the stack machine executor
// no dependencies; imported by every other file of the block
`default_nettype none

package smx_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int NUM_REGS    = 32;
   localparam int DATA_WIDTH  = 32;

   // fixed field widths of the item and result ports
   localparam int OP_W   = 3;
   localparam int IMM_W  = 32;
   localparam int REG_W  = 5;
   localparam int ST_W   = 3;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int OUT_W  = 32;

   typedef enum logic [OP_W-1:0] {
      OP_HLT  = 3'd0,
      OP_PSH  = 3'd1,
      OP_ADD  = 3'd2,
      OP_MUL  = 3'd3,
      OP_POP  = 3'd4,
      OP_LOAD = 3'd5
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK      = 3'd0,
      ST_HALT    = 3'd1,
      ST_IGNORED = 3'd2,
      ST_UNDER   = 3'd3,
      ST_ILLEGAL = 3'd4,
      ST_OVER    = 3'd5,
      ST_BADREG  = 3'd6
   } status_type;

   // what one stack cell loads on a step
   typedef enum logic [1:0] {
      SEL_HOLD  = 2'd0,
      SEL_ABOVE = 2'd1,
      SEL_BELOW = 2'd2
   } cell_sel_type;

   typedef struct packed {
      status_type         status;
      logic               running_next;
      logic [CNT_W-1:0]   count_next;
      cell_sel_type       sel_top;
      cell_sel_type       sel_rest;
      logic               reg_write;
   } step_ctl_type;

endpackage

`default_nettype wire

// ----- design/smx_cell.sv -----
// one stack cell: holds one operand entry and shifts with its neighbors
// depends on smx_pkg
`default_nettype none

module smx_cell
   import smx_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  enable,
   input  wire cell_sel_type          sel,
   input  wire logic [DATA_WIDTH-1:0] above,
   input  wire logic [DATA_WIDTH-1:0] below,
   output logic      [DATA_WIDTH-1:0] value
);

   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_in;

   always_comb begin
      case (sel)
         SEL_ABOVE: value_in = above;
         SEL_BELOW: value_in = below;
         default:   value_in = value_ff;
      endcase
   end

   // entries are undefined until pushed, so no reset
   always_ff @(posedge clock) begin
      if (enable) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

`default_nettype wire

// ----- design/smx_ctrl.sv -----
// instruction decode, checks and alu of the stack machine executor
// depends on smx_pkg
`default_nettype none

module smx_ctrl
   import smx_pkg::*;
(
   input  wire logic                  running,
   input  wire logic [CNT_W-1:0]      count,
   input  wire logic [OP_W-1:0]       op,
   input  wire logic [IMM_W-1:0]      immediate,
   input  wire logic [REG_W-1:0]      target_reg,
   input  wire logic [DATA_WIDTH-1:0] top_value,
   input  wire logic [DATA_WIDTH-1:0] second_value,
   output step_ctl_type               ctl,
   output logic      [DATA_WIDTH-1:0] new_top,
   output logic      [DATA_WIDTH-1:0] top_next
);

   logic [DATA_WIDTH-1:0] imm_ext;
   logic [DATA_WIDTH-1:0] sum;
   logic [DATA_WIDTH-1:0] prod;
   logic                  is_full;
   logic                  lt_one;
   logic                  lt_two;
   logic                  bad_reg;

   assign imm_ext = DATA_WIDTH'(signed'(immediate));
   assign sum     = top_value + second_value;
   assign prod    = top_value * second_value;
   assign is_full = (count >= CNT_W'(STACK_DEPTH));
   assign lt_one  = (count == '0);
   assign lt_two  = (count < CNT_W'(2));
   assign bad_reg = (int'(target_reg) >= NUM_REGS);

   always_comb begin
      ctl.status       = ST_OK;
      ctl.running_next = running;
      ctl.count_next   = count;
      ctl.sel_top      = SEL_HOLD;
      ctl.sel_rest     = SEL_HOLD;
      ctl.reg_write    = 1'b0;
      new_top          = imm_ext;
      if (!running) begin
         ctl.status = ST_IGNORED;
      end else begin
         unique case (op)
            OP_HLT: begin
               ctl.status       = ST_HALT;
               ctl.running_next = 1'b0;
            end
            OP_PSH: begin
               if (is_full) begin
                  ctl.status       = ST_OVER;
                  ctl.running_next = 1'b0;
               end else begin
                  ctl.sel_top    = SEL_ABOVE;
                  ctl.sel_rest   = SEL_ABOVE;
                  ctl.count_next = count + CNT_W'(1);
               end
            end
            OP_ADD, OP_MUL: begin
               if (lt_two) begin
                  ctl.status       = ST_UNDER;
                  ctl.running_next = 1'b0;
               end else begin
                  new_top        = (op == OP_ADD) ? sum : prod;
                  ctl.sel_top    = SEL_ABOVE;
                  ctl.sel_rest   = SEL_BELOW;
                  ctl.count_next = count - CNT_W'(1);
               end
            end
            OP_POP: begin
               if (lt_one) begin
                  ctl.status       = ST_UNDER;
                  ctl.running_next = 1'b0;
               end else begin
                  ctl.sel_top    = SEL_BELOW;
                  ctl.sel_rest   = SEL_BELOW;
                  ctl.count_next = count - CNT_W'(1);
               end
            end
            OP_LOAD: begin
               if (lt_one) begin
                  ctl.status       = ST_UNDER;
                  ctl.running_next = 1'b0;
               end else if (bad_reg) begin
                  ctl.status       = ST_BADREG;
                  ctl.running_next = 1'b0;
               end else begin
                  ctl.sel_top    = SEL_BELOW;
                  ctl.sel_rest   = SEL_BELOW;
                  ctl.count_next = count - CNT_W'(1);
                  ctl.reg_write  = 1'b1;
               end
            end
            default: begin
               ctl.status       = ST_ILLEGAL;
               ctl.running_next = 1'b0;
            end
         endcase
      end
   end

   // top of stack after the step, zero when empty
   always_comb begin
      if (ctl.count_next == '0) begin
         top_next = '0;
      end else begin
         case (ctl.sel_top)
            SEL_ABOVE: top_next = new_top;
            SEL_BELOW: top_next = second_value;
            default:   top_next = top_value;
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- design/stack_machine_executor_top.sv -----
// top level of the stack machine executor: cell chain, control and result register
// depends on smx_pkg, smx_cell and smx_ctrl
`default_nettype none

// Runs one stack-machine instruction per request transfer and returns one response
// transfer per instruction, in order. Throughput is one instruction per clock while
// no response is held back by rsp_stall: the operand stack is a chain of
// STACK_DEPTH cells with the top in cell 0, every instruction shifts the chain by
// at most one place, and add and multiply combine the two top cells in a single
// adder or 32x32 multiplier, so the next request is taken in the next cycle. Each
// response is registered; the request side stalls only while a response is held
// back by rsp_stall. After a halt or any error status the machine stays stopped
// until reset and answers every further request with the ignored status. Loads
// report the popped value, its register index and rsp_reg_write on the response; the
// register contents themselves are not read back by any instruction, so the
// response is where a consumer picks them up. Stack entries need no clearing
// after reset: only entries below the depth are ever shown.

module stack_machine_executor_top
   import smx_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic        [OP_W-1:0]  req_op,
   input  wire logic signed [IMM_W-1:0] req_immediate,
   input  wire logic        [REG_W-1:0] req_target_reg,
   // response channel
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic             [ST_W-1:0]  rsp_status,
   output logic signed      [OUT_W-1:0] rsp_top_value,
   output logic             [CNT_W-1:0] rsp_stack_depth,
   output logic                         rsp_reg_write,
   output logic             [REG_W-1:0] rsp_reg_index,
   output logic signed      [OUT_W-1:0] rsp_reg_value
);

   logic                  req_accept;
   step_ctl_type          ctl;
   logic [DATA_WIDTH-1:0] new_top;
   logic [DATA_WIDTH-1:0] top_next;
   logic [DATA_WIDTH-1:0] cell_value [STACK_DEPTH];

   // machine state
   logic                  running_ff;
   logic                  running_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;

   // response register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   status_type            rsp_status_ff;
   logic [OUT_W-1:0]      rsp_top_ff;
   logic [CNT_W-1:0]      rsp_depth_ff;
   logic                  rsp_write_ff;
   logic [REG_W-1:0]      rsp_index_ff;
   logic [OUT_W-1:0]      rsp_value_ff;

   // take a new request whenever the response slot is free or draining this cycle
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   smx_ctrl u_ctrl (
      .running      (running_ff),
      .count        (count_ff),
      .op           (req_op),
      .immediate    (req_immediate),
      .target_reg   (req_target_reg),
      .top_value    (cell_value[0]),
      .second_value (cell_value[1]),
      .ctl          (ctl),
      .new_top      (new_top),
      .top_next     (top_next)
   );

   // operand stack: cell 0 is the top, higher cells are deeper
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] above;
      logic [DATA_WIDTH-1:0] below;
      cell_sel_type          sel;

      if (i == 0) begin : g_top
         assign above = new_top;
         assign sel   = ctl.sel_top;
      end else begin : g_mid
         assign above = cell_value[i-1];
         assign sel   = ctl.sel_rest;
      end

      if (i == STACK_DEPTH - 1) begin : g_last
         assign below = cell_value[i];
      end else begin : g_inner
         assign below = cell_value[i+1];
      end

      smx_cell u_cell (
         .clock  (clock),
         .enable (req_accept),
         .sel    (sel),
         .above  (above),
         .below  (below),
         .value  (cell_value[i])
      );
   end

   assign running_in   = req_accept ? ctl.running_next : running_ff;
   assign count_in     = req_accept ? ctl.count_next : count_ff;
   assign rsp_valid_in = req_accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         running_ff   <= running_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded on each request transfer
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_status_ff <= ctl.status;
         rsp_top_ff    <= OUT_W'(top_next);
         rsp_depth_ff  <= ctl.count_next;
         rsp_write_ff  <= ctl.reg_write;
         rsp_index_ff  <= ctl.reg_write ? req_target_reg : '0;
         rsp_value_ff  <= ctl.reg_write ? OUT_W'(cell_value[0]) : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_top_value   = signed'(rsp_top_ff);
   assign rsp_stack_depth = rsp_depth_ff;
   assign rsp_reg_write   = rsp_write_ff;
   assign rsp_reg_index   = rsp_index_ff;
   assign rsp_reg_value   = signed'(rsp_value_ff);

   // a stopped machine never restarts without reset
   a_stays_stopped: assert property (@(posedge clock) disable iff (reset)
      !running_ff |=> !running_ff)
      else $error("machine restarted after stopping");

   // requests taken while stopped come back as ignored
   a_ignored_status: assert property (@(posedge clock) disable iff (reset)
      req_accept && !running_ff |=> rsp_valid_ff && rsp_status_ff == ST_IGNORED)
      else $error("stopped machine did not report ignored");

   // a register write only goes with an ok status
   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_write_ff |-> rsp_status_ff == ST_OK)
      else $error("register write with error status");

   // stack depth moves only on a request transfer and stays in range
   a_depth_stable: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(count_ff) && count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack depth changed without a transfer");

endmodule

`default_nettype wire
